@@ hw/rtl/java_subset_token_lexer_unit_defines.svh @@
// Assertion macros shared by the lexer RTL.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef JAVA_SUBSET_TOKEN_LEXER_UNIT_DEFINES_SVH
`define JAVA_SUBSET_TOKEN_LEXER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define JSTL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define JSTL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/jstl_pkg.sv @@
// Shared types, token codes and classification functions for the lexer.
// No dependencies.
`default_nettype none
package jstl_pkg;

    localparam int KEYWORD_CHARS_DEF = 8;
    localparam int OFFSET_BITS_DEF   = 32;
    localparam int KW_COUNT          = 14;
    localparam int KW_MAX_LEN        = 7;

    localparam logic [23:0] LINE_MAX = 24'hFFFFFF;
    localparam logic [15:0] COL_MAX  = 16'hFFFF;
    localparam logic [15:0] SIZE_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_NUM,
        MODE_OP,
        MODE_REMARK
    } scan_mode_t;

    localparam logic [5:0] TK_EOF     = 6'd0;
    localparam logic [5:0] TK_IDENT   = 6'd1;
    localparam logic [5:0] TK_INT     = 6'd2;
    localparam logic [5:0] TK_KW_BASE = 6'd3;
    localparam logic [5:0] TK_PLUS    = 6'd17;
    localparam logic [5:0] TK_MINUS   = 6'd18;
    localparam logic [5:0] TK_STAR    = 6'd19;
    localparam logic [5:0] TK_SLASH   = 6'd20;
    localparam logic [5:0] TK_PCT     = 6'd21;
    localparam logic [5:0] TK_EQEQ    = 6'd22;
    localparam logic [5:0] TK_NE      = 6'd23;
    localparam logic [5:0] TK_LT      = 6'd24;
    localparam logic [5:0] TK_LE      = 6'd25;
    localparam logic [5:0] TK_GT      = 6'd26;
    localparam logic [5:0] TK_GE      = 6'd27;
    localparam logic [5:0] TK_ANDAND  = 6'd28;
    localparam logic [5:0] TK_OROR    = 6'd29;
    localparam logic [5:0] TK_NOT     = 6'd30;
    localparam logic [5:0] TK_ASSIGN  = 6'd31;
    localparam logic [5:0] TK_SEMI    = 6'd32;
    localparam logic [5:0] TK_COMMA   = 6'd33;
    localparam logic [5:0] TK_LPAREN  = 6'd34;
    localparam logic [5:0] TK_RPAREN  = 6'd35;
    localparam logic [5:0] TK_LBRACE  = 6'd36;
    localparam logic [5:0] TK_RBRACE  = 6'd37;
    localparam logic [5:0] TK_UNKNOWN = 6'd38;

    typedef struct packed {
        logic [5:0]  kind;
        logic [23:0] line;
        logic [15:0] column;
        logic [31:0] offset;
        logic [15:0] length;
        logic        last;
    } token_t;

    // Keyword spellings, first character in the most significant used byte.
    localparam logic [55:0] KW_TEXT [KW_COUNT] = '{
        56'("public"), 56'("class"), 56'("static"), 56'("if"),
        56'("else"), 56'("while"), 56'("for"), 56'("return"),
        56'("int"), 56'("long"), 56'("boolean"), 56'("void"),
        56'("true"), 56'("false")
    };
    localparam int KW_LEN [KW_COUNT] = '{6, 5, 6, 2, 4, 5, 3, 6, 3, 4, 7, 4, 4, 5};

    function automatic logic is_letter(input logic [7:0] b);
        return (b == "_") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    endfunction

    function automatic logic is_num(input logic [7:0] b);
        return (b >= "0" && b <= "9");
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D) ||
               (b == 8'h0C) || (b == 8'h0B);
    endfunction

    function automatic logic is_op_start(input logic [7:0] b);
        return (b == "=") || (b == "!") || (b == "<") || (b == ">") ||
               (b == "&") || (b == "|") || (b == "/");
    endfunction

    function automatic logic [5:0] lone_kind(input logic [7:0] a);
        logic [5:0] k;
        case (a)
            "+":     k = TK_PLUS;
            "-":     k = TK_MINUS;
            "*":     k = TK_STAR;
            "/":     k = TK_SLASH;
            "%":     k = TK_PCT;
            "<":     k = TK_LT;
            ">":     k = TK_GT;
            "!":     k = TK_NOT;
            "=":     k = TK_ASSIGN;
            ";":     k = TK_SEMI;
            ",":     k = TK_COMMA;
            "(":     k = TK_LPAREN;
            ")":     k = TK_RPAREN;
            "{":     k = TK_LBRACE;
            "}":     k = TK_RBRACE;
            default: k = TK_UNKNOWN;
        endcase
        return k;
    endfunction

    // Returns TK_EOF when the two bytes form no operator.
    function automatic logic [5:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
        logic [5:0] k;
        k = TK_EOF;
        if (b == "=") begin
            if (a == "=") k = TK_EQEQ;
            else if (a == "!") k = TK_NE;
            else if (a == "<") k = TK_LE;
            else if (a == ">") k = TK_GE;
        end
        if (a == "&" && b == "&") k = TK_ANDAND;
        if (a == "|" && b == "|") k = TK_OROR;
        return k;
    endfunction

    // c[j] is the j-th character of the identifier.
    function automatic logic [5:0] word_kind(input logic [KW_MAX_LEN-1:0][7:0] c,
                                             input logic [15:0] size);
        logic [5:0] k;
        logic       same;
        k = TK_IDENT;
        for (int i = KW_COUNT - 1; i >= 0; i--) begin
            same = (size == 16'(KW_LEN[i]));
            for (int j = 0; j < KW_MAX_LEN; j++) begin
                if (j < KW_LEN[i] && c[j] != KW_TEXT[i][(KW_LEN[i]-1-j)*8 +: 8]) same = 1'b0;
            end
            if (same) k = TK_KW_BASE + 6'(i);
        end
        return k;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/jstl_scan.sv @@
// Scanner state registers and the per-byte next-state and token logic.
// Depends on jstl_pkg.
`default_nettype none
module jstl_scan
    import jstl_pkg::*;
#(
    parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF,
    parameter int OFFSET_BITS   = OFFSET_BITS_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_fire,
    input  wire logic       in_kind,
    input  wire logic [7:0] in_byte,
    output logic [1:0]      push_cnt,
    output token_t          tok0,
    output token_t          tok1
);

    localparam int KIDX_W = $clog2(KEYWORD_CHARS);

    scan_mode_t             mode_reg, mode_next;
    logic [7:0]             pend_reg, pend_next;
    logic                   acr_reg, acr_next;
    logic [23:0]            line_reg, line_next;
    logic [15:0]            col_reg, col_next;
    logic [OFFSET_BITS-1:0] off_reg, off_next;
    logic [23:0]            sline_reg, sline_next;
    logic [15:0]            scol_reg, scol_next;
    logic [OFFSET_BITS-1:0] soff_reg, soff_next;
    logic [15:0]            size_reg, size_next;
    logic [7:0]             kbuf_reg [KEYWORD_CHARS];
    logic                   kbuf_we;
    logic [KIDX_W-1:0]      kbuf_idx;

    logic [KW_MAX_LEN-1:0][7:0] kw_chars;

    always_comb begin
        for (int j = 0; j < KW_MAX_LEN; j++) kw_chars[j] = kbuf_reg[j];
    end

    always_comb begin
        token_t     t;
        logic       adv;
        logic       fresh;
        logic [5:0] pk;
        logic [1:0] cnt;
        token_t     s0, s1;

        mode_next  = mode_reg;
        pend_next  = pend_reg;
        acr_next   = acr_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        off_next   = off_reg;
        sline_next = sline_reg;
        scol_next  = scol_reg;
        soff_next  = soff_reg;
        size_next  = size_reg;
        kbuf_we    = 1'b0;
        kbuf_idx   = '0;
        adv        = 1'b0;
        fresh      = 1'b0;
        cnt        = 2'd0;
        s0         = '0;
        s1         = '0;
        t          = '0;
        pk         = pair_kind(pend_reg, in_byte);

        // The open token, as a flush would emit it.
        t.line   = sline_reg;
        t.column = scol_reg;
        t.offset = 32'(soff_reg);
        t.length = size_reg;
        case (mode_reg)
            MODE_WORD: t.kind = word_kind(kw_chars, size_reg);
            MODE_NUM:  t.kind = TK_INT;
            MODE_OP: begin
                t.kind   = lone_kind(pend_reg);
                t.length = 16'd1;
            end
            default:   t.kind = TK_EOF;
        endcase

        if (in_kind) begin
            if (mode_reg == MODE_WORD || mode_reg == MODE_NUM || mode_reg == MODE_OP) begin
                s0  = t;
                cnt = 2'd1;
            end
            mode_next = MODE_IDLE;
            acr_next  = 1'b0;
            t         = '0;
            t.kind    = TK_EOF;
            t.line    = line_reg;
            t.column  = col_reg;
            t.offset  = 32'(off_reg);
            if (cnt == 2'd0) s0 = t;
            else s1 = t;
            cnt = cnt + 2'd1;
        end else if (acr_reg && in_byte == 8'h0A) begin
            // Second half of a CR LF pair: the line already moved on.
            acr_next = 1'b0;
            off_next = off_reg + 1'b1;
        end else begin
            acr_next = 1'b0;
            case (mode_reg)
                MODE_WORD: begin
                    if (is_letter(in_byte) || is_num(in_byte)) begin
                        if (size_reg < 16'(KEYWORD_CHARS)) begin
                            kbuf_we  = 1'b1;
                            kbuf_idx = size_reg[KIDX_W-1:0];
                        end
                        if (size_reg < SIZE_MAX) size_next = size_reg + 16'd1;
                        adv = 1'b1;
                    end else begin
                        s0    = t;
                        cnt   = 2'd1;
                        fresh = 1'b1;
                    end
                end
                MODE_NUM: begin
                    if (is_num(in_byte)) begin
                        if (size_reg < SIZE_MAX) size_next = size_reg + 16'd1;
                        adv = 1'b1;
                    end else begin
                        s0    = t;
                        cnt   = 2'd1;
                        fresh = 1'b1;
                    end
                end
                MODE_OP: begin
                    if (pk != TK_EOF) begin
                        s0        = t;
                        s0.kind   = pk;
                        s0.length = 16'd2;
                        cnt       = 2'd1;
                        mode_next = MODE_IDLE;
                        adv       = 1'b1;
                    end else if (pend_reg == "/" && in_byte == "/") begin
                        mode_next = MODE_REMARK;
                        adv       = 1'b1;
                    end else begin
                        s0    = t;
                        cnt   = 2'd1;
                        fresh = 1'b1;
                    end
                end
                MODE_REMARK: begin
                    if (in_byte != 8'h0A && in_byte != 8'h0D) adv = 1'b1;
                    else fresh = 1'b1;
                end
                default: fresh = 1'b1;
            endcase

            if (fresh) begin
                mode_next = MODE_IDLE;
                adv       = 1'b1;
                if (is_space(in_byte)) begin
                    mode_next = MODE_IDLE;
                end else if (is_letter(in_byte) || is_num(in_byte) ||
                             is_op_start(in_byte)) begin
                    sline_next = line_reg;
                    scol_next  = col_reg;
                    soff_next  = off_reg;
                    size_next  = 16'd1;
                    if (is_letter(in_byte)) begin
                        mode_next = MODE_WORD;
                        kbuf_we   = 1'b1;
                        kbuf_idx  = '0;
                    end else if (is_num(in_byte)) begin
                        mode_next = MODE_NUM;
                    end else begin
                        mode_next = MODE_OP;
                        pend_next = in_byte;
                    end
                end else begin
                    t        = '0;
                    t.kind   = lone_kind(in_byte);
                    t.line   = line_reg;
                    t.column = col_reg;
                    t.offset = 32'(off_reg);
                    t.length = 16'd1;
                    if (cnt == 2'd0) s0 = t;
                    else s1 = t;
                    cnt = cnt + 2'd1;
                end
            end

            if (adv) begin
                off_next = off_reg + 1'b1;
                if (in_byte == 8'h0D || in_byte == 8'h0A) begin
                    if (line_reg < LINE_MAX) line_next = line_reg + 24'd1;
                    col_next = 16'd1;
                    acr_next = (in_byte == 8'h0D);
                end else if (col_reg < COL_MAX) begin
                    col_next = col_reg + 16'd1;
                end
            end
        end

        if (cnt == 2'd2) s1.last = 1'b1;
        else s0.last = 1'b1;
        tok0     = s0;
        tok1     = s1;
        push_cnt = in_fire ? cnt : 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            pend_reg  <= '0;
            acr_reg   <= 1'b0;
            line_reg  <= 24'd1;
            col_reg   <= 16'd1;
            off_reg   <= '0;
            sline_reg <= 24'd1;
            scol_reg  <= 16'd1;
            soff_reg  <= '0;
            size_reg  <= '0;
        end else if (in_fire) begin
            mode_reg  <= mode_next;
            pend_reg  <= pend_next;
            acr_reg   <= acr_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            off_reg   <= off_next;
            sline_reg <= sline_next;
            scol_reg  <= scol_next;
            soff_reg  <= soff_next;
            size_reg  <= size_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && kbuf_we) kbuf_reg[kbuf_idx] <= in_byte;
    end

endmodule
`default_nettype wire

@@ hw/rtl/jstl_outq.sv @@
// Four-entry token queue: takes up to two tokens a cycle, gives out one.
// Depends on jstl_pkg and the shared assertion macros.
`default_nettype none
`include "java_subset_token_lexer_unit_defines.svh"
module jstl_outq
    import jstl_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  [1:0] push_cnt,
    input  wire token_t tok0,
    input  wire token_t tok1,
    output logic       room,
    output logic       out_valid,
    input  wire logic  out_ready,
    output token_t     out_tok
);

    token_t     mem_reg [4];
    logic [1:0] wr_reg, wr_next;
    logic [1:0] rd_reg, rd_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (cnt_reg != 3'd0);
    assign out_tok   = mem_reg[rd_reg];
    // Room for the worst case of two tokens from one request.
    assign room      = (cnt_reg <= 3'd2);

    always_comb begin
        wr_next  = wr_reg + push_cnt;
        rd_next  = rd_reg + 2'(pop);
        cnt_next = cnt_reg + 3'(push_cnt) - 3'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) mem_reg[wr_reg] <= tok0;
        if (push_cnt == 2'd2) mem_reg[wr_reg + 2'd1] <= tok1;
    end

    `JSTL_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= 3'd4, "token queue count overran")
    `JSTL_ASSERT_NOW(a_push_room, push_cnt != 2'd0, room, "token pushed without room")
    `JSTL_ASSERT_NEXT(a_cnt_track, push_cnt == 2'd2 && !pop,
                      cnt_reg == $past(cnt_reg) + 3'd2, "queue count lost a token")

endmodule
`default_nettype wire

@@ hw/rtl/java_subset_token_lexer_unit.sv @@
// A token is written to the queue when the request that ends it is accepted, and is then offered on m_.
// Throughput: one request per cycle while the queue has room; a request that yields two tokens
// (a flush plus a new token, or a flush plus end-of-file) leaves one queued,
// so steady two-token traffic drains at one token per cycle.
// Reset: synchronous active-low aresetn clears scanner state and the queue.
// Depends on jstl_pkg, jstl_scan and jstl_outq.
`default_nettype none
module java_subset_token_lexer_unit
    import jstl_pkg::*;
#(
    parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEF,
    parameter int OFFSET_BITS   = OFFSET_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_kind,
    input  wire logic [7:0]  s_data_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [5:0]       m_token_kind,
    output logic [23:0]      m_start_line,
    output logic [15:0]      m_start_column,
    output logic [31:0]      m_start_offset,
    output logic [15:0]      m_token_length,
    output logic             m_last_of_run
);

    logic       in_fire;
    logic [1:0] push_cnt;
    token_t     tok0, tok1, out_tok;

    assign in_fire = s_valid && s_ready;

    jstl_scan #(
        .KEYWORD_CHARS(KEYWORD_CHARS),
        .OFFSET_BITS  (OFFSET_BITS)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .in_kind (s_kind),
        .in_byte (s_data_byte),
        .push_cnt(push_cnt),
        .tok0    (tok0),
        .tok1    (tok1)
    );

    jstl_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_cnt (push_cnt),
        .tok0     (tok0),
        .tok1     (tok1),
        .room     (s_ready),
        .out_valid(m_valid),
        .out_ready(m_ready),
        .out_tok  (out_tok)
    );

    assign m_token_kind   = out_tok.kind;
    assign m_start_line   = out_tok.line;
    assign m_start_column = out_tok.column;
    assign m_start_offset = out_tok.offset;
    assign m_token_length = out_tok.length;
    assign m_last_of_run  = out_tok.last;

endmodule
`default_nettype wire
